// File: hw/rtl/plcr_pkg.sv
package plcr_pkg;

  // Field widths of the streaming payloads.
  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 5;
  localparam int unsigned SlotW  = 2;

  // A page number is the address with its low twelve offset bits dropped,
  // which is the same as masking with 0xFFFFF000.
  localparam int unsigned PageLsb = 12;
  localparam int unsigned VpnW    = DataW - PageLsb;

  // Number of frame fields carried by every result.
  localparam int unsigned OutFrames = 4;

  // Input and output tdata widths, rounded up to whole bytes.
  localparam int unsigned InBits  = IndexW + DataW + DataW;
  localparam int unsigned InTdW   = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits = 1 + 1 + SlotW + OutFrames * DataW;
  localparam int unsigned OutTdW  = ((OutBits + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ACCESS = 1'b1
  } op_e;

  // Status that the page-table scanner reports to the frame logic.
  typedef struct packed {
    logic              clearing;
    logic              done;
    logic              found;
    logic [DataW-1:0]  page;
  } scan_status_t;

endpackage

// File: hw/rtl/plcr_pt_scan.sv
// Page-table memory with its clearing pass, load writes and a pipelined
// first-match scan (one entry read per cycle, each compared in the cycle after its read).
module plcr_pt_scan #(
  parameter int unsigned PT_ENTRIES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [plcr_pkg::IndexW-1:0]       wr_index_i,
  input  logic [plcr_pkg::DataW-1:0]        wr_value_i,
  input  logic                              start_i,
  input  logic [plcr_pkg::VpnW-1:0]         vpn_i,
  output plcr_pkg::scan_status_t            status_o
);

  localparam int unsigned AW = $clog2(PT_ENTRIES);
  localparam int unsigned CW = $clog2(PT_ENTRIES + 1);
  localparam int unsigned IW = (AW > plcr_pkg::IndexW) ? AW : plcr_pkg::IndexW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 cnt_q;
  logic                          rvalid_q;
  logic                          rlast_q;
  logic [plcr_pkg::DataW-1:0]    rdata_q;
  logic [plcr_pkg::VpnW-1:0]     vpn_q;
  logic                          done_q;
  logic                          found_q;
  logic [plcr_pkg::DataW-1:0]    page_q;

  logic [plcr_pkg::DataW-1:0]    mem_q [PT_ENTRIES];

  logic [IW-1:0]                 wr_idx_ext;
  logic                          wr_in_range;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [plcr_pkg::DataW-1:0]    mem_wdata;
  logic                          mem_re;
  logic                          is_last;
  logic                          match;

  assign wr_idx_ext  = IW'(wr_index_i);
  assign wr_in_range = {1'b0, wr_idx_ext} < (IW + 1)'(PT_ENTRIES);
  assign is_last     = cnt_q == CW'(PT_ENTRIES - 1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx_ext[AW-1:0];
    mem_wdata = wr_value_i;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[AW-1:0];
      mem_wdata = '0;
    end else if (wr_en_i && wr_in_range) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_q == S_SCAN) && (cnt_q != CW'(PT_ENTRIES));
  assign match  = rdata_q[plcr_pkg::DataW-1:plcr_pkg::PageLsb] == vpn_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[cnt_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      rlast_q  <= 1'b0;
      vpn_q    <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      page_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (is_last) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_IDLE: begin
          if (start_i) begin
            vpn_q    <= vpn_i;
            cnt_q    <= '0;
            rvalid_q <= 1'b0;
            rlast_q  <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            cnt_q    <= cnt_q + CW'(1);
            rvalid_q <= 1'b1;
            rlast_q  <= is_last;
          end else begin
            rvalid_q <= 1'b0;
          end
          if (rvalid_q) begin
            if (match) begin
              done_q  <= 1'b1;
              found_q <= 1'b1;
              page_q  <= rdata_q;
              state_q <= S_IDLE;
            end else if (rlast_q) begin
              done_q  <= 1'b1;
              found_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o.clearing = state_q == S_CLEAR;
  assign status_o.done     = done_q;
  assign status_o.found    = found_q;
  assign status_o.page     = page_q;

endmodule

// File: hw/rtl/page_lookup_clock_replacement.sv
// Page lookup with clock (second chance) frame replacement. After reset the
// page table is swept to zero, one entry per cycle, and no item is accepted
// during that pass. A load item (tuser = 0) writes one page-table entry and
// gives no result; a load to a slot at or beyond PT_ENTRIES is dropped. An
// access item (tuser = 1) scans the page-table memory for the first entry
// whose upper 20 bits match the address, reading one entry per cycle
// through its single read port; the scan ends early on a match. The matched
// page then either hits a resident frame or runs the clock hand, one frame
// per cycle, until it places the page. The result is then loaded into the
// output register once the output is free, and only after that can the next
// item be taken, so one item is in work at a time. Each access returns
// exactly one result transfer with the fault and hit flags, the frame
// holding the page and the contents of frames 0 to 3 (zero means empty, and
// frames beyond FRAMES read as zero). When no entry matches, the result
// flags a fault and nothing in the block changes.
module page_lookup_clock_replacement #(
  parameter int unsigned PT_ENTRIES = 32,
  parameter int unsigned FRAMES     = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata from bit 0 up: entry_index[4:0], entry_value[31:0],
  // access_address[31:0], zero fill.
  input  logic [plcr_pkg::InTdW-1:0]       s_axis_tdata_i,
  // tuser: op (0 = load, 1 = access).
  input  logic                             s_axis_tuser_i,
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata from bit 0 up: fault, hit, frame_slot[1:0], frame_zero[31:0],
  // frame_one[31:0], frame_two[31:0], frame_three[31:0], zero fill.
  output logic [plcr_pkg::OutTdW-1:0]      m_axis_tdata_o
);

  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned DW = plcr_pkg::DataW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_PLACE,
    S_DONE
  } state_e;

  // Unpack the input item.
  logic [plcr_pkg::IndexW-1:0] in_index;
  logic [DW-1:0]               in_value;
  logic [DW-1:0]               in_address;
  plcr_pkg::op_e               in_op;

  assign in_index   = s_axis_tdata_i[plcr_pkg::IndexW-1:0];
  assign in_value   = s_axis_tdata_i[plcr_pkg::IndexW +: DW];
  assign in_address = s_axis_tdata_i[plcr_pkg::IndexW + DW +: DW];
  assign in_op      = plcr_pkg::op_e'(s_axis_tuser_i);

  state_e                  state_q;
  logic [DW-1:0]           page_q;
  logic [DW-1:0]           frames_q [FRAMES];
  logic [FRAMES-1:0]       use_q;
  logic [FW-1:0]           hand_q;
  logic                    fault_q;
  logic                    hit_q;
  logic [FW-1:0]           where_q;
  logic                    out_valid_q;
  logic [plcr_pkg::OutTdW-1:0] out_data_q;

  plcr_pkg::scan_status_t  scan_status;
  logic                    in_fire;
  logic                    out_free;

  assign s_axis_tready_o = (state_q == S_IDLE) && !scan_status.clearing;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // The page-table memory and its scan sit in their own unit.
  plcr_pt_scan #(
    .PT_ENTRIES (PT_ENTRIES)
  ) u_pt_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_fire && (in_op == plcr_pkg::OP_LOAD)),
    .wr_index_i (in_index),
    .wr_value_i (in_value),
    .start_i    (in_fire && (in_op == plcr_pkg::OP_ACCESS)),
    .vpn_i      (in_address[DW-1:plcr_pkg::PageLsb]),
    .status_o   (scan_status)
  );

  // Resident check: the lowest frame holding the page wins. An empty frame
  // holds zero, so a page value of zero hits the first empty frame.
  logic          hit_any;
  logic [FW-1:0] hit_idx;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (frames_q[k] == page_q) begin
        hit_any = 1'b1;
        hit_idx = FW'(k);
      end
    end
  end

  logic [FW-1:0] hand_next;
  assign hand_next = (hand_q == FW'(FRAMES - 1)) ? '0 : hand_q + FW'(1);

  // Frames reported in the result; those beyond FRAMES read as zero.
  logic [DW-1:0] out_frame [plcr_pkg::OutFrames];

  for (genvar g = 0; g < plcr_pkg::OutFrames; g++) begin : g_out_frame
    if (g < FRAMES) begin : g_used
      assign out_frame[g] = frames_q[g];
    end else begin : g_unused
      assign out_frame[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      page_q      <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        frames_q[k] <= '0;
      end
      use_q       <= '0;
      hand_q      <= '0;
      fault_q     <= 1'b0;
      hit_q       <= 1'b0;
      where_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // In S_DONE the output register is reloaded instead, so valid stays high.
      if (out_valid_q && m_axis_tready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (in_op == plcr_pkg::OP_ACCESS)) begin
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (scan_status.done) begin
            if (scan_status.found) begin
              page_q  <= scan_status.page;
              state_q <= S_PLACE;
            end else begin
              fault_q <= 1'b1;
              hit_q   <= 1'b0;
              where_q <= '0;
              state_q <= S_DONE;
            end
          end
        end
        S_PLACE: begin
          fault_q <= 1'b0;
          if (hit_any) begin
            use_q[hit_idx] <= 1'b1;
            hit_q          <= 1'b1;
            where_q        <= hit_idx;
            state_q        <= S_DONE;
          end else if (use_q[hand_q]) begin
            // Second chance: clear the use bit and move on.
            use_q[hand_q] <= 1'b0;
            hand_q        <= hand_next;
          end else begin
            frames_q[hand_q] <= page_q;
            use_q[hand_q]    <= 1'b1;
            hit_q            <= 1'b0;
            where_q          <= hand_q;
            hand_q           <= hand_next;
            state_q          <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= plcr_pkg::OutTdW'({out_frame[3], out_frame[2], out_frame[1],
                                              out_frame[0], plcr_pkg::SlotW'(where_q),
                                              hit_q, fault_q});
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes; the mirror below keeps the same ones.
  localparam int unsigned PtEntries = 32;
  localparam int unsigned Frames    = 4;

  // Cycles with no transfer on either side before the run is declared hung. The
  // slowest item is a full page-table scan plus a full clock sweep behind a
  // receiver that may hold off, and the clearing pass after reset comes on top.
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StuckLimit  = 3000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned PoolSize    = 6;

  // One result transfer, unpacked from m_axis_tdata_o. Members run from the
  // top bit down, so fault lands on bit 0.
  typedef struct packed {
    logic [3:0][plcr_pkg::DataW-1:0] frames;
    logic [plcr_pkg::SlotW-1:0]      slot;
    logic                            hit;
    logic                            fault;
  } frame_report_t;

  // One row of the directed table. When has_want is set, the row carries its
  // result typed in by hand and the mirror is only advanced.
  typedef struct {
    plcr_pkg::op_e               op;
    logic [plcr_pkg::IndexW-1:0] idx;
    logic [plcr_pkg::DataW-1:0]  val;
    logic [plcr_pkg::DataW-1:0]  addr;
    bit                          has_want;
    frame_report_t               want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [plcr_pkg::InTdW-1:0]  s_axis_tdata;
  logic                        s_axis_tuser;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [plcr_pkg::OutTdW-1:0] m_axis_tdata;

  page_lookup_clock_replacement #(
    .PT_ENTRIES(PtEntries),
    .FRAMES    (Frames)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  // Mirror of the block's state: page table, frame contents, use bits and the
  // clock hand.
  logic [plcr_pkg::DataW-1:0] pt_mirror    [PtEntries];
  logic [plcr_pkg::DataW-1:0] frame_mirror [Frames];
  logic                       use_mirror   [Frames];
  int unsigned                hand_mirror;

  frame_report_t              pending_reports[$];
  stim_row_t                  directed_rows[$];
  logic [plcr_pkg::DataW-1:0] page_pool[PoolSize];

  int unsigned mismatch_count;
  int unsigned stuck_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Works out what one accepted item does to the mirror. Returns 1 when the
  // item produces a result transfer, which only an access does.
  function automatic bit predict_item(input plcr_pkg::op_e op,
                                      input logic [plcr_pkg::IndexW-1:0] idx,
                                      input logic [plcr_pkg::DataW-1:0] val,
                                      input logic [plcr_pkg::DataW-1:0] addr,
                                      output frame_report_t rep);
    int                         entry;
    int                         resident;
    int unsigned                h;
    bit                         placed;
    logic [plcr_pkg::DataW-1:0] page;
    rep = '0;
    if (op == plcr_pkg::OP_LOAD) begin
      pt_mirror[idx] = val;
      return 1'b0;
    end
    entry = -1;
    for (int k = 0; k < PtEntries; k++) begin
      if (entry < 0 && pt_mirror[k][plcr_pkg::DataW-1:plcr_pkg::PageLsb] ==
          addr[plcr_pkg::DataW-1:plcr_pkg::PageLsb]) begin
        entry = k;
      end
    end
    if (entry < 0) begin
      // No page-table entry covers the address: flag it and leave the state alone.
      rep.fault = 1'b1;
    end else begin
      page = pt_mirror[entry];
      resident = -1;
      for (int k = 0; k < Frames; k++) begin
        if (resident < 0 && frame_mirror[k] == page) begin
          resident = k;
        end
      end
      if (resident >= 0) begin
        // A page value of zero lands here too, on the first empty frame.
        rep.hit = 1'b1;
        rep.slot = resident[plcr_pkg::SlotW-1:0];
        use_mirror[resident] = 1'b1;
      end else begin
        // Second chance: clear set use bits until a clear one is found.
        placed = 1'b0;
        for (int s = 0; s <= Frames; s++) begin
          if (!placed) begin
            h = hand_mirror;
            hand_mirror = (h + 1) % Frames;
            if (use_mirror[h]) begin
              use_mirror[h] = 1'b0;
            end else begin
              frame_mirror[h] = page;
              use_mirror[h] = 1'b1;
              rep.slot = h[plcr_pkg::SlotW-1:0];
              placed = 1'b1;
            end
          end
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      rep.frames[k] = (k < Frames) ? frame_mirror[k] : '0;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [plcr_pkg::DataW-1:0] got,
                               input logic [plcr_pkg::DataW-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input plcr_pkg::op_e op, input logic [plcr_pkg::IndexW-1:0] idx,
                         input logic [plcr_pkg::DataW-1:0] val,
                         input logic [plcr_pkg::DataW-1:0] addr,
                         input bit has_want, input frame_report_t want);
    stim_row_t row;
    row.op = op;
    row.idx = idx;
    row.val = val;
    row.addr = addr;
    row.has_want = has_want;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Offers one item, idling first at the current sender rate, and waits for the
  // transfer. On acceptance the expected result, if any, is queued.
  task automatic send_item(input plcr_pkg::op_e op, input logic [plcr_pkg::IndexW-1:0] idx,
                           input logic [plcr_pkg::DataW-1:0] val,
                           input logic [plcr_pkg::DataW-1:0] addr,
                           input bit has_want, input frame_report_t want);
    frame_report_t rep;
    bit            gives_result;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(plcr_pkg::InTdW - plcr_pkg::InBits){1'b0}}, addr, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    gives_result = predict_item(op, idx, val, addr, rep);
    if (gives_result) begin
      pending_reports.push_back(has_want ? want : rep);
    end
  endtask

  // Draws one random item. Most addresses and page values come from a small
  // pool of pages, a little larger than the frame count, so that lookups find
  // entries and the clock hand has to evict. Some accesses aim at whatever a
  // table slot holds; the rest is noise: faults, page zero and fully random words.
  task automatic draw_item(output plcr_pkg::op_e op,
                           output logic [plcr_pkg::IndexW-1:0] idx,
                           output logic [plcr_pkg::DataW-1:0] val,
                           output logic [plcr_pkg::DataW-1:0] addr);
    int unsigned                pick;
    logic [plcr_pkg::DataW-1:0] offset;
    idx    = plcr_pkg::IndexW'($urandom_range(PtEntries - 1));
    val    = $urandom;
    addr   = $urandom;
    offset = $urandom_range((1 << plcr_pkg::PageLsb) - 1);
    pick   = $urandom_range(99);
    if ($urandom_range(99) < 30) begin
      op = plcr_pkg::OP_LOAD;
      if (pick < 70) begin
        val = page_pool[$urandom_range(PoolSize - 1)] | offset;
      end else if (pick < 80) begin
        val = '0;
      end
    end else begin
      op = plcr_pkg::OP_ACCESS;
      if (pick < 70) begin
        addr = page_pool[$urandom_range(PoolSize - 1)] | offset;
      end else if (pick < 85) begin
        // Aim at whatever some table slot holds right now.
        addr = {pt_mirror[$urandom_range(PtEntries - 1)][plcr_pkg::DataW-1:plcr_pkg::PageLsb],
                offset[plcr_pkg::PageLsb-1:0]};
      end else if (pick < 90) begin
        addr = '0;
      end
    end
  endtask

  // Result receiver. It idles at the rate of the current phase and, once asked,
  // holds tready low through one long hold-off so that the block fills up and stalls its
  // input while the sender keeps offering.
  initial m_axis_tready = 1'b0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares every result transfer, field by field, with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    frame_report_t got;
    frame_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[plcr_pkg::OutBits-1:0];
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected result", got.frames[0], '0);
      end else begin
        want = pending_reports.pop_front();
        if (got.fault !== want.fault) flag_mismatch("fault", got.fault, want.fault);
        if (got.hit !== want.hit) flag_mismatch("hit", got.hit, want.hit);
        if (got.slot !== want.slot) flag_mismatch("frame_slot", got.slot, want.slot);
        for (int k = 0; k < 4; k++) begin
          if (got.frames[k] !== want.frames[k]) begin
            flag_mismatch($sformatf("frame %0d", k), got.frames[k], want.frames[k]);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a transfer.
  initial stuck_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    plcr_pkg::op_e               op;
    logic [plcr_pkg::IndexW-1:0] idx;
    logic [plcr_pkg::DataW-1:0]  val;
    logic [plcr_pkg::DataW-1:0]  addr;
    frame_report_t               want;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = plcr_pkg::OP_LOAD;
    s_axis_tdata   = '0;
    mismatch_count = 0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    hand_mirror    = 0;
    send_idle_pct  = 21;
    recv_idle_pct  = 60;
    for (int k = 0; k < PtEntries; k++) pt_mirror[k] = '0;
    for (int k = 0; k < Frames; k++) begin
      frame_mirror[k] = '0;
      use_mirror[k]   = 1'b0;
    end
    page_pool[0] = 32'hFFFF_F000;
    for (int k = 1; k < PoolSize; k++) page_pool[k] = $urandom & 32'hFFFF_F000;

    // Directed part. Right after reset every table entry is zero, so address
    // zero finds entry 0, whose value zero matches the empty frame 0 as a hit.
    want = '0;
    want.hit = 1'b1;
    add_row(plcr_pkg::OP_ACCESS, 5'd0, 32'h0, 32'h0000_0000, 1'b1, want);
    // No zero entry covers the top page, so this is a fault with empty frames.
    want = '0;
    want.fault = 1'b1;
    add_row(plcr_pkg::OP_ACCESS, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, want);
    want = '0;
    add_row(plcr_pkg::OP_LOAD,   5'd0,  32'hFFFF_FFFF, 32'h0, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd31, 32'h7FFF_F555, 32'h0, 1'b0, want);
    // Miss: the sweep clears frame 0's use bit and places the page in frame 1.
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'hFFFF_F000, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd1,  32'h1234_5678, 32'h0, 1'b0, want);
    // Same page number in a later slot; lookups must keep picking slot 1.
    add_row(plcr_pkg::OP_LOAD,   5'd2,  32'h1234_5000, 32'h0, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd3,  32'hABCD_E001, 32'h0, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd4,  32'h0000_1FFF, 32'h0, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd5,  32'h8000_0000, 32'h0, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h1234_5ABC, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'hABCD_E000, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h0000_1000, 1'b0, want);
    // Only the last slot covers this page, so the scan runs the whole table.
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h7FFF_F000, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h1234_5FFF, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h8000_0FFF, 1'b0, want);
    // Page zero with every frame taken has to be evicted into a frame, and
    // then hits that frame by value.
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h0000_0123, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h0000_0FFF, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'h5555_5000, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_F000, 1'b0, want);
    add_row(plcr_pkg::OP_LOAD,   5'd31, 32'hFFFF_FFFF, 32'h0, 1'b0, want);
    add_row(plcr_pkg::OP_ACCESS, 5'd0,  32'h0, 32'hFFFF_FABC, 1'b0, want);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].addr, directed_rows[i].has_want, directed_rows[i].want);
    end

    // Random part in three phases: a slow receiver, then a slow sender, then
    // no idling at all. The long receiver hold-off falls in the first phase.
    want = '0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct <= 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct <= 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 0 && n == 50) hold_req <= 1'b1;
        draw_item(op, idx, val, addr);
        send_item(op, idx, val, addr, 1'b0, want);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: page_lookup_clock_replacement.f
hw/rtl/plcr_pkg.sv
hw/rtl/plcr_pt_scan.sv
hw/rtl/page_lookup_clock_replacement.sv
bench/tb.sv
